>>> sv/mpeq_pkg.sv
package mpeq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Field widths fixed by the item format.
  localparam int DATA_W  = 32;
  localparam int PRIO_W  = 32;
  localparam int OCC_W   = 5;
  localparam int ENTRY_W = PRIO_W + DATA_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_SCAN  = 2'd1,
    SEQ_SHIFT = 2'd2,
    SEQ_DONE  = 2'd3
  } seq_state_e;

endpackage

>>> sv/mpeq_stream_if.sv
// Request channel: one queue operation per transfer.
interface mpeq_req_if;
  logic                                valid;
  logic                                ready;
  mpeq_pkg::op_e                       opcode;
  logic signed [mpeq_pkg::DATA_W-1:0]  item_value;
  logic signed [mpeq_pkg::PRIO_W-1:0]  item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

// Response channel: one result per request.
interface mpeq_rsp_if;
  logic                                valid;
  logic                                ready;
  mpeq_pkg::status_e                   status;
  logic signed [mpeq_pkg::DATA_W-1:0]  removed_value;
  logic        [mpeq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

>>> sv/mpeq_ram.sv
module mpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/max_priority_extract_queue.sv
// Bounded max-priority queue of QUEUE_DEPTH entries, held unsorted in arrival order in a
// single-port-read RAM. An insert, an insert on a full queue (overflow) and a remove on an
// empty queue (underflow) finish in the transfer cycle, and the result is shown from the
// next cycle on. A remove with N entries held reads every entry once to find the largest
// priority (the earliest on ties), then moves the entries after it down one slot; both
// passes go through the one RAM read port, and the result is loaded in SEQ_DONE once the
// response register is free. The next request is taken only after the sequencer is back
// in SEQ_IDLE.
// No new request is taken until the current one has loaded its result, and a request is
// only taken while the response register is empty or its result transfers in that cycle.
module max_priority_extract_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  mpeq_req_if.sink      in_i,
  mpeq_rsp_if.source    out_o
);

  localparam int IDX_W   = mpeq_pkg::IDX_W;
  localparam int COUNT_W = mpeq_pkg::COUNT_W;

  mpeq_pkg::seq_state_e state_q, state_d;

  logic [COUNT_W-1:0]                count_q, count_d;
  logic [IDX_W-1:0]                  idx_q, idx_d;
  logic [IDX_W-1:0]                  didx_q, didx_d;
  logic                              rvld_q, rvld_d;
  logic [IDX_W-1:0]                  best_idx_q, best_idx_d;
  logic signed [mpeq_pkg::PRIO_W-1:0] best_prio_q, best_prio_d;
  logic [mpeq_pkg::DATA_W-1:0]       best_val_q, best_val_d;

  logic                              out_valid_q, out_valid_d;
  mpeq_pkg::status_e                 out_status_q, out_status_d;
  logic [mpeq_pkg::DATA_W-1:0]       out_value_q, out_value_d;
  logic [mpeq_pkg::OCC_W-1:0]        out_occ_q, out_occ_d;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [mpeq_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [mpeq_pkg::ENTRY_W-1:0]      ram_rdata;

  logic                              out_free;
  logic                              in_xfer;
  logic [IDX_W-1:0]                  last_idx;
  logic signed [mpeq_pkg::PRIO_W-1:0] rd_prio;
  logic [mpeq_pkg::DATA_W-1:0]       rd_val;
  logic                              take_new;
  logic                              scan_end;

  // Entry storage: priority in the upper half, data in the lower half.
  mpeq_ram #(
    .WIDTH (mpeq_pkg::ENTRY_W),
    .DEPTH (mpeq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and shared helper signals.
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == mpeq_pkg::SEQ_IDLE) && out_free;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign last_idx  = IDX_W'(count_q - COUNT_W'(1));
  assign rd_prio   = ram_rdata[mpeq_pkg::ENTRY_W-1:mpeq_pkg::DATA_W];
  assign rd_val    = ram_rdata[mpeq_pkg::DATA_W-1:0];
  // The first entry seeds the scan, so the most negative priority can still win.
  assign take_new  = (didx_q == '0) || (rd_prio > best_prio_q);
  assign scan_end  = rvld_q && (didx_q == last_idx);

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_value = out_value_q;
  assign out_o.occupancy     = out_occ_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpeq_pkg::SEQ_IDLE: begin
        if (in_xfer && (in_i.opcode == mpeq_pkg::OP_REMOVE) && (count_q != '0)) begin
          state_d = mpeq_pkg::SEQ_SCAN;
        end
      end
      mpeq_pkg::SEQ_SCAN: begin
        if (scan_end) begin
          state_d = mpeq_pkg::SEQ_SHIFT;
        end
      end
      mpeq_pkg::SEQ_SHIFT: begin
        if (!(idx_q < last_idx)) begin
          state_d = mpeq_pkg::SEQ_DONE;
        end
      end
      mpeq_pkg::SEQ_DONE: begin
        if (out_free) begin
          state_d = mpeq_pkg::SEQ_IDLE;
        end
      end
      default: state_d = mpeq_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath, RAM controls and response register loads.
  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    didx_d       = didx_q;
    rvld_d       = rvld_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_val_d   = best_val_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = IDX_W'(count_q);
    ram_wdata    = {in_i.item_priority, in_i.item_value};
    ram_raddr    = idx_q;

    case (state_q)
      mpeq_pkg::SEQ_IDLE: begin
        if (in_xfer) begin
          if (in_i.opcode == mpeq_pkg::OP_INSERT) begin
            out_valid_d = 1'b1;
            out_value_d = '0;
            if (count_q == COUNT_W'(mpeq_pkg::QUEUE_DEPTH)) begin
              out_status_d = mpeq_pkg::ST_OVERFLOW;
              out_occ_d    = mpeq_pkg::OCC_W'(count_q);
            end else begin
              ram_we       = 1'b1;
              count_d      = count_q + COUNT_W'(1);
              out_status_d = mpeq_pkg::ST_INSERTED;
              out_occ_d    = mpeq_pkg::OCC_W'(count_q + COUNT_W'(1));
            end
          end else if (count_q == '0) begin
            out_valid_d  = 1'b1;
            out_value_d  = '0;
            out_status_d = mpeq_pkg::ST_UNDERFLOW;
            out_occ_d    = mpeq_pkg::OCC_W'(count_q);
          end else begin
            idx_d  = '0;
            rvld_d = 1'b0;
          end
        end
      end
      mpeq_pkg::SEQ_SCAN: begin
        // Read one entry per cycle and compare it on the next cycle, once the RAM returns it.
        ram_raddr = idx_q;
        idx_d     = IDX_W'(idx_q + IDX_W'(1));
        didx_d    = idx_q;
        rvld_d    = 1'b1;
        if (rvld_q && take_new) begin
          best_idx_d  = didx_q;
          best_prio_d = rd_prio;
          best_val_d  = rd_val;
        end
        if (scan_end) begin
          idx_d  = take_new ? didx_q : best_idx_q;
          rvld_d = 1'b0;
        end
      end
      mpeq_pkg::SEQ_SHIFT: begin
        // Read slot i+1 and write it to slot i on the following cycle.
        ram_we    = rvld_q;
        ram_waddr = didx_q;
        ram_wdata = ram_rdata;
        ram_raddr = IDX_W'(idx_q + IDX_W'(1));
        if (idx_q < last_idx) begin
          rvld_d = 1'b1;
          didx_d = idx_q;
          idx_d  = IDX_W'(idx_q + IDX_W'(1));
        end else begin
          rvld_d = 1'b0;
        end
      end
      mpeq_pkg::SEQ_DONE: begin
        if (out_free) begin
          count_d      = count_q - COUNT_W'(1);
          out_valid_d  = 1'b1;
          out_status_d = mpeq_pkg::ST_REMOVED;
          out_value_d  = best_val_q;
          out_occ_d    = mpeq_pkg::OCC_W'(count_q - COUNT_W'(1));
        end
      end
      default: begin
        rvld_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpeq_pkg::SEQ_IDLE;
      count_q     <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    didx_q       <= didx_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_val_q   <= best_val_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_occ_q    <= out_occ_d;
  end

endmodule

>>> sv/mpeq_checker.sv
module mpeq_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  mpeq_pkg::status_e                 out_status_i,
  input  logic [mpeq_pkg::DATA_W-1:0]       out_value_i,
  input  logic [mpeq_pkg::OCC_W-1:0]        out_occ_i
);

  // A pending result stays until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped before transfer");

  // A request is only taken when the response register can be loaded.
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> (!out_valid_i || out_ready_i))
    else $error("request taken while response register is blocked");

  // Only a removal carries data.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != mpeq_pkg::ST_REMOVED) |-> (out_value_i == '0))
    else $error("nonzero data on a non-removal result");

  // Overflow reports a full queue and underflow an empty one.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((out_status_i != mpeq_pkg::ST_OVERFLOW) ||
       (out_occ_i == mpeq_pkg::OCC_W'(mpeq_pkg::QUEUE_DEPTH))) &&
      ((out_status_i != mpeq_pkg::ST_UNDERFLOW) || (out_occ_i == '0)))
    else $error("occupancy does not match overflow or underflow");

endmodule

bind max_priority_extract_queue mpeq_checker u_mpeq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_value_i  (out_o.removed_value),
  .out_occ_i    (out_o.occupancy)
);

>>> tb/tb_max_priority_extract_queue.sv
`timescale 1ns / 1ps

module tb_max_priority_extract_queue;
  import mpeq_pkg::*;

  localparam logic [DATA_W-1:0] INT_MIN_BITS = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX_BITS = 32'h7fff_ffff;
  localparam int IDLE_PCT      = 36;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = 100;
  localparam int STALL_CYCLES  = 150;
  localparam int TAIL_CYCLES   = 2 * QUEUE_DEPTH + 8;
  localparam int DRAIN_LIMIT   = 20000;

  // One expected or observed response transfer.
  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  removed_value;
    logic [OCC_W-1:0]   occupancy;
  } queue_result_t;

  // Shadow copy of the queue contents plus the responses still owed by the block.
  class priority_queue_shadow;
    logic signed [DATA_W-1:0] held_values[QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] held_prios[QUEUE_DEPTH];
    int                       held_count;
    queue_result_t            owed_results[$];
    int                       errors;
    int                       removals;
    int                       underflows;
    int                       overflows;
    int                       inserts;
    int                       checked;

    function new();
      held_count = 0;
      errors     = 0;
      removals   = 0;
      underflows = 0;
      overflows  = 0;
      inserts    = 0;
      checked    = 0;
    endfunction

    // Apply one accepted request to the shadow and queue the response it owes.
    function void note_request(op_e op, logic [DATA_W-1:0] value, logic [PRIO_W-1:0] prio);
      queue_result_t res;
      int            best;
      res.removed_value = '0;
      if (op == OP_INSERT) begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          held_values[held_count] = value;
          held_prios[held_count]  = prio;
          held_count++;
          res.status = ST_INSERTED;
        end
      end else if (held_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        // The first held entry seeds the search, so a minimum priority can still win.
        best = 0;
        for (int i = 1; i < held_count; i++) begin
          if (held_prios[i] > held_prios[best]) best = i;
        end
        res.removed_value = held_values[best];
        for (int i = best; i + 1 < held_count; i++) begin
          held_values[i] = held_values[i + 1];
          held_prios[i]  = held_prios[i + 1];
        end
        held_count--;
        res.status = ST_REMOVED;
      end
      res.occupancy = OCC_W'(held_count);
      owed_results.push_back(res);
    endfunction

    // Compare one response transfer with the oldest outstanding expectation.
    function void check_response(status_e status, logic [DATA_W-1:0] value,
                                 logic [OCC_W-1:0] occupancy);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: response with nothing outstanding: status %s value %h occupancy %0d",
                 $time, status.name(), value, occupancy);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      case (want.status)
        ST_INSERTED:  inserts++;
        ST_REMOVED:   removals++;
        ST_UNDERFLOW: underflows++;
        default:      overflows++;
      endcase
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %s, actual %s",
                 $time, want.status.name(), status.name());
        errors++;
      end
      if (value !== want.removed_value) begin
        $display("%0t: removed_value mismatch: expected %h, actual %h",
                 $time, want.removed_value, value);
        errors++;
      end
      if (occupancy !== want.occupancy) begin
        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                 $time, want.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mpeq_req_if req_if ();
  mpeq_rsp_if rsp_if ();

  max_priority_extract_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  priority_queue_shadow shadow_queue = new();

  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int stall_left    = 0;

  // Free-running 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request, after a random number of idle cycles unless the sender is calm, and wait for its transfer.
  task automatic send_request(input op_e op, input logic [DATA_W-1:0] value,
                              input logic [PRIO_W-1:0] prio);
    @(negedge clk_i);
    while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         = 1'b1;
    req_if.opcode        = op;
    req_if.item_value    = value;
    req_if.item_priority = prio;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow_queue.note_request(op, value, prio);
  endtask

  // Stop offering and wait until every owed response has come back or the drain limit runs out.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (shadow_queue.owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Priorities lean toward a narrow band so that ties are frequent.
  function automatic logic [PRIO_W-1:0] random_priority();
    logic [PRIO_W-1:0] prio;
    case ($urandom_range(9))
      0:       prio = INT_MIN_BITS;
      1:       prio = INT_MAX_BITS;
      2, 3, 4, 5: begin
        prio = $urandom_range(6);
        prio = prio - 3;
      end
      default: prio = $urandom;
    endcase
    return prio;
  endfunction

  // Response side: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = receiver_calm || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        shadow_queue.check_response(rsp_if.status, rsp_if.removed_value, rsp_if.occupancy);
      end
    end
  end

  // Request side: directed corners first, then phases with different insert mixes.
  initial begin
    int insert_pct;
    req_if.valid         = 1'b0;
    req_if.opcode        = OP_INSERT;
    req_if.item_value    = '0;
    req_if.item_priority = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue, then a single entry of minimum priority, then empty again.
    send_request(OP_REMOVE, $urandom, $urandom);
    send_request(OP_INSERT, INT_MAX_BITS, INT_MIN_BITS);
    send_request(OP_REMOVE, $urandom, $urandom);
    send_request(OP_REMOVE, $urandom, $urandom);

    // Fill to capacity with ties and extreme priorities, overflow once, then take two.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       send_request(OP_INSERT, INT_MIN_BITS, 32'd7);
        1:       send_request(OP_INSERT, 32'hffff_ffff, 32'd7);
        2:       send_request(OP_INSERT, 32'h0000_0000, INT_MAX_BITS);
        3:       send_request(OP_INSERT, INT_MAX_BITS, INT_MAX_BITS);
        4:       send_request(OP_INSERT, 32'h5555_5555, INT_MIN_BITS);
        default: send_request(OP_INSERT, $urandom, 32'(i) - 32'd8);
      endcase
    end
    send_request(OP_INSERT, 32'hdead_beef, INT_MAX_BITS);
    send_request(OP_REMOVE, $urandom, $urandom);
    send_request(OP_REMOVE, $urandom, $urandom);
    wait_for_drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 6)
        0:       insert_pct = 80;
        1:       insert_pct = 25;
        2:       insert_pct = 55;
        3:       insert_pct = 92;
        4:       insert_pct = 10;
        default: insert_pct = 50;
      endcase
      sender_calm   = (phase == 4);
      receiver_calm = (phase == 4);

      // Hold the response side off while requests keep coming, so the input stalls.
      if (phase == 2) begin
        stall_left = STALL_CYCLES;
        for (int i = 0; i < 12; i++) begin
          send_request(OP_INSERT, $urandom, random_priority());
        end
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < insert_pct) begin
          send_request(OP_INSERT, $urandom, random_priority());
        end else begin
          send_request(OP_REMOVE, $urandom, $urandom);
        end
      end
      wait_for_drain();
    end

    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (shadow_queue.owed_results.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, shadow_queue.owed_results.size());
      shadow_queue.errors++;
    end
    $display("Checked %0d responses: %0d inserts, %0d removals, %0d underflows, %0d overflows.",
             shadow_queue.checked, shadow_queue.inserts, shadow_queue.removals,
             shadow_queue.underflows, shadow_queue.overflows);
    $display("Mix covered empty and full queues, priority ties, extremes and a long stall.");
    if (shadow_queue.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
